// File: rtl/temc_pkg.sv
// Shared types, constants and lookup helpers for the tetrahedron edge mask block.
// Holds the transaction structs, the status codes and the even permutation table.
// No dependencies.
package temc_pkg;

    localparam int unsigned NUM_EDGES  = 6;
    localparam int unsigned NUM_EVEN   = 12;
    localparam int unsigned IDX_W      = $clog2(NUM_EVEN);

    typedef logic [1:0] t_vtx;
    typedef logic [2:0] t_edge;
    typedef logic [5:0] t_mask;
    // Packed vertex order, position 0 in the top two bits.
    typedef logic [7:0] t_order;

    localparam logic CMD_PERMUTE      = 1'b0;
    localparam logic CMD_CANONICALIZE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_PERM = 2'd1,
        ST_ODD      = 2'd2
    } t_status;

    typedef struct packed {
        logic  cmd;
        t_mask edge_mask;
        t_vtx  order_v0;
        t_vtx  order_v1;
        t_vtx  order_v2;
        t_vtx  order_v3;
    } t_in_item;

    typedef struct packed {
        t_mask   out_mask;
        t_vtx    out_v0;
        t_vtx    out_v1;
        t_vtx    out_v2;
        t_vtx    out_v3;
        t_status status;
    } t_out_item;

    // Endpoints of each edge, edges ordered 01, 02, 03, 12, 13, 23.
    localparam t_vtx EDGE_A [NUM_EDGES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
    localparam t_vtx EDGE_B [NUM_EDGES] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

    // The twelve even permutations of 0..3 in lexicographic order.
    localparam t_order EVEN_ORDERS [NUM_EVEN] = '{
        8'h1B, 8'h2D, 8'h36, 8'h4E, 8'h63, 8'h78,
        8'h87, 8'h9C, 8'hB1, 8'hC9, 8'hD2, 8'hE4
    };

    // Edge joining two vertices, symmetric; a repeated vertex maps to edge 0.
    function automatic t_edge pair_edge(input t_vtx a, input t_vtx b);
        t_edge e;
        case ({a, b})
            4'b0001, 4'b0100: e = 3'd0;
            4'b0010, 4'b1000: e = 3'd1;
            4'b0011, 4'b1100: e = 3'd2;
            4'b0110, 4'b1001: e = 3'd3;
            4'b0111, 4'b1101: e = 3'd4;
            4'b1011, 4'b1110: e = 3'd5;
            default:          e = 3'd0;
        endcase
        return e;
    endfunction

    function automatic t_vtx order_at(input t_order ord, input t_vtx pos);
        t_vtx v;
        case (pos)
            2'd0:    v = ord[7:6];
            2'd1:    v = ord[5:4];
            2'd2:    v = ord[3:2];
            default: v = ord[1:0];
        endcase
        return v;
    endfunction

endpackage

// File: rtl/temc_remap.sv
// Relabels the vertices of one edge mask by a given vertex order.
// Depends on temc_pkg.
module temc_remap (
    input  temc_pkg::t_mask  i_mask,
    input  temc_pkg::t_order i_order,
    output temc_pkg::t_mask  o_mask
);
    import temc_pkg::*;

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            o_mask[e] = i_mask[pair_edge(order_at(i_order, EDGE_A[e]),
                                         order_at(i_order, EDGE_B[e]))];
        end
    end

endmodule

// File: rtl/temc_check.sv
// Classifies a vertex order as a repeated-vertex, odd or valid even permutation.
// Depends on temc_pkg.
module temc_check (
    input  temc_pkg::t_order  i_order,
    output temc_pkg::t_status o_status
);
    import temc_pkg::*;

    t_vtx v [4];
    logic has_repeat;
    logic odd;

    always_comb begin
        for (int p = 0; p < 4; p++) begin
            v[p] = order_at(i_order, t_vtx'(p));
        end
    end

    always_comb begin
        has_repeat = 1'b0;
        odd        = 1'b0;
        for (int i = 0; i < 4; i++) begin
            for (int j = i + 1; j < 4; j++) begin
                has_repeat = has_repeat | (v[i] == v[j]);
                odd        = odd ^ (v[i] > v[j]);
            end
        end
    end

    // A repeated vertex takes precedence over parity.
    always_comb begin
        if (has_repeat) begin
            o_status = ST_NOT_PERM;
        end else if (odd) begin
            o_status = ST_ODD;
        end else begin
            o_status = ST_OK;
        end
    end

endmodule

// File: rtl/temc_canon.sv
// Finds the smallest remapped mask over the twelve even vertex orders.
// Depends on temc_pkg and temc_remap.
module temc_canon (
    input  temc_pkg::t_mask  i_mask,
    output temc_pkg::t_mask  o_mask,
    output temc_pkg::t_order o_order
);
    import temc_pkg::*;

    typedef logic [IDX_W-1:0] t_idx;

    t_mask cand [NUM_EVEN];
    t_mask m1 [6];
    t_idx  x1 [6];
    t_mask m2 [3];
    t_idx  x2 [3];
    t_mask m3;
    t_idx  x3;
    t_idx  best;

    for (genvar k = 0; k < NUM_EVEN; k++) begin : g_cand
        temc_remap u_remap (
            .i_mask  (i_mask),
            .i_order (EVEN_ORDERS[k]),
            .o_mask  (cand[k])
        );
    end

    // Each compare keeps the left (earlier) candidate on a tie, so the
    // first order reaching the minimum wins.
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            if (cand[2*k+1] < cand[2*k]) begin
                m1[k] = cand[2*k+1];
                x1[k] = t_idx'(2*k+1);
            end else begin
                m1[k] = cand[2*k];
                x1[k] = t_idx'(2*k);
            end
        end
        for (int k = 0; k < 3; k++) begin
            if (m1[2*k+1] < m1[2*k]) begin
                m2[k] = m1[2*k+1];
                x2[k] = x1[2*k+1];
            end else begin
                m2[k] = m1[2*k];
                x2[k] = x1[2*k];
            end
        end
        if (m2[1] < m2[0]) begin
            m3 = m2[1];
            x3 = x2[1];
        end else begin
            m3 = m2[0];
            x3 = x2[0];
        end
        if (m2[2] < m3) begin
            o_mask = m2[2];
            best   = x2[2];
        end else begin
            o_mask = m3;
            best   = x3;
        end
    end

    assign o_order = EVEN_ORDERS[best];

endmodule

// File: rtl/tet_edge_mask_canonicalize_top.sv
// Top level of the tetrahedron edge mask permute and canonicalize block.
// Depends on temc_pkg, temc_remap, temc_check and temc_canon.
//
// Usage: an input transaction carries a command, a 6-bit edge mask and a
// vertex order. The permute command checks the order and remaps the mask;
// the canonicalize command ignores the order and returns the smallest mask
// over the twelve even vertex orders together with the first order that
// gives it. Exactly one result transaction leaves for each input.
// Both channels use valid and stall; a transaction moves at a clock edge
// with valid high and stall low.
// A transaction accepted into the input register moves on into the output
// register, where the receiver can take it. Throughput is one transaction
// per cycle while the receiver does not stall, set by the input register
// feeding combinational remap and compare logic into the result register.
// While the receiver stalls, the result register holds its transaction and
// one more item can still be taken into the input register; only when both
// are full does the block stall its sender.
// Reset (synchronous, active low) empties both registers; no other state.
module tet_edge_mask_canonicalize_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  temc_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output temc_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import temc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic      out_hold;
    t_order    in_order;
    t_mask     perm_mask;
    t_status   perm_status;
    t_mask     canon_mask;
    t_order    canon_order;

    assign out_hold   = r_out_valid && i_out_stall;
    assign o_in_stall = r_in_valid && out_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    assign in_order = {r_in.order_v0, r_in.order_v1, r_in.order_v2, r_in.order_v3};

    temc_remap u_remap (
        .i_mask  (r_in.edge_mask),
        .i_order (in_order),
        .o_mask  (perm_mask)
    );

    temc_check u_check (
        .i_order  (in_order),
        .o_status (perm_status)
    );

    temc_canon u_canon (
        .i_mask  (r_in.edge_mask),
        .o_mask  (canon_mask),
        .o_order (canon_order)
    );

    always_comb begin
        if (r_in.cmd == CMD_CANONICALIZE) begin
            n_out.out_mask = canon_mask;
            n_out.out_v0   = canon_order[7:6];
            n_out.out_v1   = canon_order[5:4];
            n_out.out_v2   = canon_order[3:2];
            n_out.out_v3   = canon_order[1:0];
            n_out.status   = ST_OK;
        end else begin
            n_out.out_mask = (perm_status == ST_OK) ? perm_mask : '0;
            n_out.out_v0   = r_in.order_v0;
            n_out.out_v1   = r_in.order_v1;
            n_out.out_v2   = r_in.order_v2;
            n_out.out_v3   = r_in.order_v3;
            n_out.status   = perm_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_hold) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_hold && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/temc_checker.sv
// Port-level checks for the tetrahedron edge mask block, bound to its top level.
// Depends on temc_pkg and tet_edge_mask_canonicalize_top.
module temc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input temc_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);
    import temc_pkg::*;

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Every accepted transaction goes on to reach the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> ##1 o_out_valid)
        else $error("accepted transaction did not reach the output");

    // The sender is only held off while a result is waiting on the receiver.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // An error status always comes with an empty mask.
    a_err_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.out_mask == '0)
        else $error("error result carries a nonzero mask");

    // A good result reports a true permutation.
    a_ok_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_OK |->
            o_out_data.out_v0 != o_out_data.out_v1 &&
            o_out_data.out_v0 != o_out_data.out_v2 &&
            o_out_data.out_v0 != o_out_data.out_v3 &&
            o_out_data.out_v1 != o_out_data.out_v2 &&
            o_out_data.out_v1 != o_out_data.out_v3 &&
            o_out_data.out_v2 != o_out_data.out_v3)
        else $error("good result with a repeated vertex");

endmodule

bind tet_edge_mask_canonicalize_top temc_checker u_temc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
